// ===== rtl/xalu_pkg.sv =====
// shared types and constants for the 32-bit x86 alu with flags
`default_nettype none

package xalu_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ACTION_W = 4;
    localparam int unsigned FLAGS_W  = 6;

    localparam int unsigned FLAG_CF = 0;
    localparam int unsigned FLAG_PF = 1;
    localparam int unsigned FLAG_AF = 2;
    localparam int unsigned FLAG_ZF = 3;
    localparam int unsigned FLAG_SF = 4;
    localparam int unsigned FLAG_OF = 5;

    localparam logic [DATA_W-1:0] SIGN_MASK = 32'h8000_0000;
    localparam logic [DATA_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;

    typedef logic [DATA_W-1:0]  word_t;
    typedef logic [FLAGS_W-1:0] flags_t;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD       = 4'd0,
        ACT_ADC       = 4'd1,
        ACT_SUB       = 4'd2,
        ACT_SBB       = 4'd3,
        ACT_CMP       = 4'd4,
        ACT_NEG       = 4'd5,
        ACT_INC       = 4'd6,
        ACT_DEC       = 4'd7,
        ACT_XADD      = 4'd8,
        ACT_CMPXCHG   = 4'd9,
        ACT_CMPXCHG8B = 4'd10,
        ACT_CWDE      = 4'd11,
        ACT_CDQ       = 4'd12
    } action_t;

    typedef struct packed {
        word_t  dest_result;
        word_t  dest_high_result;
        logic   dest_write;
        word_t  src_result;
        logic   src_write;
        word_t  accum_result;
        word_t  accum_high_result;
        logic   accum_write;
        logic   accum_high_write;
        flags_t flags;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/xalu_core.sv =====
// combinational datapath: shared adder and subtractor, flag logic and result select
`default_nettype none

module xalu_core
(
    input  wire logic [xalu_pkg::ACTION_W-1:0] action,
    input  wire xalu_pkg::word_t               dest_operand,
    input  wire xalu_pkg::word_t               dest_high,
    input  wire xalu_pkg::word_t               src_operand,
    input  wire xalu_pkg::word_t               src_high,
    input  wire xalu_pkg::word_t               accum_low,
    input  wire xalu_pkg::word_t               accum_high,
    input  wire xalu_pkg::flags_t              flags_in,
    output xalu_pkg::result_t                  result
);

    import xalu_pkg::*;

    function automatic flags_t arith_flags(input word_t a, input word_t b, input word_t r,
                                           input logic carry, input logic is_sub);
        flags_t f;
        word_t  mix;
        begin
            mix              = a ^ b ^ r;
            f                = '0;
            f[FLAG_CF]       = carry;
            f[FLAG_PF]       = ~^r[7:0];
            f[FLAG_AF]       = mix[4];
            f[FLAG_ZF]       = (r == '0);
            f[FLAG_SF]       = r[DATA_W-1];
            if (is_sub)
            begin
                f[FLAG_OF] = (a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ r[DATA_W-1]);
            end
            else
            begin
                f[FLAG_OF] = ~(a[DATA_W-1] ^ b[DATA_W-1]) & (a[DATA_W-1] ^ r[DATA_W-1]);
            end
            return f;
        end
    endfunction

    action_t         act;
    logic            cf;
    word_t           add_a;
    word_t           add_b;
    logic            add_c;
    word_t           sub_a;
    word_t           sub_b;
    logic            sub_c;
    logic [DATA_W:0] add_sum;
    logic [DATA_W:0] sub_diff;
    word_t           add_r;
    word_t           sub_r;
    flags_t          add_flags;
    flags_t          sub_flags;
    logic            low_match;
    logic            pair_match;

    assign act = action_t'(action);
    assign cf  = flags_in[FLAG_CF];

    // operand steering for the shared adder and subtractor
    always_comb
    begin
        add_a = dest_operand;
        add_b = (act == ACT_INC) ? word_t'(1) : src_operand;
        add_c = (act == ACT_ADC) ? cf : 1'b0;

        sub_a = dest_operand;
        sub_b = src_operand;
        sub_c = (act == ACT_SBB) ? cf : 1'b0;
        case (act)
            ACT_NEG:
            begin
                sub_a = '0;
                sub_b = dest_operand;
            end
            ACT_CMPXCHG:
            begin
                sub_a = accum_low;
                sub_b = dest_operand;
            end
            ACT_DEC:
            begin
                sub_b = word_t'(1);
            end
            default:
            begin
                sub_a = dest_operand;
            end
        endcase
    end

    assign add_sum  = {1'b0, add_a} + {1'b0, add_b} + {{DATA_W{1'b0}}, add_c};
    assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b} - {{DATA_W{1'b0}}, sub_c};
    assign add_r    = add_sum[DATA_W-1:0];
    assign sub_r    = sub_diff[DATA_W-1:0];

    assign add_flags  = arith_flags(add_a, add_b, add_r, add_sum[DATA_W], 1'b0);
    assign sub_flags  = arith_flags(sub_a, sub_b, sub_r, sub_diff[DATA_W], 1'b1);

    assign low_match  = (accum_low == dest_operand);
    assign pair_match = low_match && (accum_high == dest_high);

    always_comb
    begin
        result       = '0;
        result.flags = flags_in;
        case (act)
            ACT_ADD, ACT_ADC:
            begin
                result.dest_result = add_r;
                result.dest_write  = 1'b1;
                result.flags       = add_flags;
            end
            ACT_SUB, ACT_SBB, ACT_NEG:
            begin
                result.dest_result = sub_r;
                result.dest_write  = 1'b1;
                result.flags       = sub_flags;
            end
            ACT_CMP:
            begin
                result.flags = sub_flags;
            end
            ACT_INC:
            begin
                result.dest_result   = add_r;
                result.dest_write    = 1'b1;
                result.flags         = add_flags;
                result.flags[FLAG_CF] = cf;
            end
            ACT_DEC:
            begin
                result.dest_result   = sub_r;
                result.dest_write    = 1'b1;
                result.flags         = sub_flags;
                result.flags[FLAG_CF] = cf;
            end
            ACT_XADD:
            begin
                result.dest_result = add_r;
                result.dest_write  = 1'b1;
                result.src_result  = dest_operand;
                result.src_write   = 1'b1;
                result.flags       = add_flags;
            end
            ACT_CMPXCHG:
            begin
                result.flags = sub_flags;
                if (low_match)
                begin
                    result.dest_result = src_operand;
                    result.dest_write  = 1'b1;
                end
                else
                begin
                    result.accum_result = dest_operand;
                    result.accum_write  = 1'b1;
                end
            end
            ACT_CMPXCHG8B:
            begin
                result.flags[FLAG_ZF] = pair_match;
                if (pair_match)
                begin
                    result.dest_result      = src_operand;
                    result.dest_high_result = src_high;
                    result.dest_write       = 1'b1;
                end
                else
                begin
                    result.accum_result      = dest_operand;
                    result.accum_high_result = dest_high;
                    result.accum_write       = 1'b1;
                    result.accum_high_write  = 1'b1;
                end
            end
            ACT_CWDE:
            begin
                result.accum_result = {{(DATA_W/2){accum_low[DATA_W/2-1]}},
                                       accum_low[DATA_W/2-1:0]};
                result.accum_write  = 1'b1;
            end
            ACT_CDQ:
            begin
                result.accum_high_result = ((accum_low & SIGN_MASK) != '0) ? ALL_ONES : '0;
                result.accum_high_write  = 1'b1;
            end
            default:
            begin
                result.flags = flags_in;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/x86_alu32_with_flags.sv =====
// 32-bit x86 integer alu with flags: top level
// usage
//   input channel: in_valid / in_stall carry one transaction holding action
//   and the operand words; it is taken on a clock edge with in_valid high and
//   in_stall low
//   output channel: out_valid / out_stall carry the new destination, source
//   and accumulator values, their write enables and the six status flags
//   from acceptance to out_valid a transaction passes one input register,
//   one adder or subtractor pass and one result register
//   throughput is one transaction per cycle while out_stall is low; the kept
//   flags are updated as a transaction moves into the result register, so
//   adc and sbb back to back see the carry of the one before
//   when out_stall is high with a result waiting, the input register keeps one
//   more transaction and then in_stall rises; the result holds until taken
//   reset (rst_n low) empties both registers and clears all kept flags
`default_nettype none

module x86_alu32_with_flags
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [3:0]  action,
    input  wire logic [31:0] dest_operand,
    input  wire logic [31:0] dest_high,
    input  wire logic [31:0] src_operand,
    input  wire logic [31:0] src_high,
    input  wire logic [31:0] accum_low,
    input  wire logic [31:0] accum_high,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      dest_result,
    output logic [31:0]      dest_high_result,
    output logic             dest_write,
    output logic [31:0]      src_result,
    output logic             src_write,
    output logic [31:0]      accum_result,
    output logic [31:0]      accum_high_result,
    output logic             accum_write,
    output logic             accum_high_write,
    output logic [5:0]       flags_out
);

    import xalu_pkg::*;

    logic                  in_valid_reg;
    logic [ACTION_W-1:0]   action_reg;
    word_t                 dest_operand_reg;
    word_t                 dest_high_reg;
    word_t                 src_operand_reg;
    word_t                 src_high_reg;
    word_t                 accum_low_reg;
    word_t                 accum_high_reg;
    flags_t                flags_reg;
    logic                  out_valid_reg;
    result_t               result_reg;
    result_t               result_next;
    logic                  advance;
    logic                  load;

    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            action_reg       <= action;
            dest_operand_reg <= dest_operand;
            dest_high_reg    <= dest_high;
            src_operand_reg  <= src_operand;
            src_high_reg     <= src_high;
            accum_low_reg    <= accum_low;
            accum_high_reg   <= accum_high;
        end
    end

    xalu_core u_core
    (
        .action       (action_reg),
        .dest_operand (dest_operand_reg),
        .dest_high    (dest_high_reg),
        .src_operand  (src_operand_reg),
        .src_high     (src_high_reg),
        .accum_low    (accum_low_reg),
        .accum_high   (accum_high_reg),
        .flags_in     (flags_reg),
        .result       (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            flags_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                flags_reg <= result_next.flags;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign dest_result       = result_reg.dest_result;
    assign dest_high_result  = result_reg.dest_high_result;
    assign dest_write        = result_reg.dest_write;
    assign src_result        = result_reg.src_result;
    assign src_write         = result_reg.src_write;
    assign accum_result      = result_reg.accum_result;
    assign accum_high_result = result_reg.accum_high_result;
    assign accum_write       = result_reg.accum_write;
    assign accum_high_write  = result_reg.accum_high_write;
    assign flags_out         = result_reg.flags;

endmodule

`default_nettype wire
